### rtl/fcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine package
// Shared types, codes and reset values of the cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 65536;
	localparam int unsigned CMP_W = 29;

	localparam logic [16:0] CLUSTER_BYTES_RST = 17'd4096;
	localparam logic [27:0] DATA_START_RST = 28'd0;
	localparam logic [16:0] ENTRIES_IN_USE_RST = 17'd65536;
	localparam logic [27:0] END_MARKER_RST = 28'hFFFFFF8;

	localparam logic [1:0] CFG_CLUSTER_BYTES = 2'd0;
	localparam logic [1:0] CFG_DATA_START = 2'd1;
	localparam logic [1:0] CFG_ENTRIES_IN_USE = 2'd2;
	localparam logic [1:0] CFG_END_MARKER = 2'd3;

	typedef enum logic [2:0] {
		OP_READ = 3'd0,
		OP_WRITE = 3'd1,
		OP_FIND = 3'd2,
		OP_APPEND = 3'd3,
		OP_TRUNC = 3'd4,
		OP_FREE = 3'd5,
		OP_SEEK = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOFREE = 3'd1,
		ST_ENDED = 3'd2,
		ST_LIMIT = 3'd3,
		ST_RANGE = 3'd4
	} st_t;

	typedef enum logic [1:0] {A_CUR, A_CL, A_IDX, A_RD} asel_t;
	typedef enum logic [1:0] {W_VAL, W_END, W_ZERO, W_IDX} wsel_t;
	typedef enum logic [1:0] {ADD_ZERO, ADD_OFF, ADD_CB} addsel_t;
	typedef enum logic [1:0] {R_RD, R_IDX, R_CUR} rsel_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_RD_WAIT, S_SCAN_RD, S_SCAN_CHK, S_APP_WALK,
		S_APP_LINK, S_APP_MARK, S_CUT_TEST, S_CUT_WR, S_FREE_FIN,
		S_SEEK_TEST, S_ADD, S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic ram_en;
		logic ram_we;
		asel_t asel;
		wsel_t wsel;
		logic cur_ld;
		logic step_inc;
		logic off_sub;
		logic idx_init;
		logic idx_inc;
		logic mul_go;
		logic mul_idx;
		addsel_t addsel;
		logic res_ld;
		rsel_t rsel;
		logic st_ld;
		st_t st_val;
		logic addr_ld;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		op_t op;
		logic cur_range;
		logic cur_end;
		logic cur_start;
		logic rd_end;
		logic rd_range;
		logic rd_zero;
		logic step_max;
		logic idx_end;
		logic off_ge;
	} sts_t;

endpackage

### rtl/fcce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module fcce_ram #(
	parameter int unsigned WIDTH = 28,
	parameter int unsigned DEPTH = 65536
) (
	input logic clk,
	input logic en,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

### rtl/fcce_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain engine datapath
// Configuration, command registers, walk counters, table RAM and address math.
// ----------------------------------------------------------------------------
module fcce_dp #(
	parameter int unsigned TABLE_ENTRIES = fcce_pkg::TABLE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input fcce_pkg::cmd_t cmd,
	output fcce_pkg::sts_t sts,
	input logic [2:0] op,
	input logic [27:0] cluster,
	input logic [27:0] value,
	input logic [31:0] offset,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [27:0] cfg_data,
	output logic [27:0] result_cluster,
	output logic [31:0] address,
	output logic [2:0] status
);
	import fcce_pkg::*;

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
	localparam int unsigned CNT_W = IDX_W + 1;
	localparam logic [CMP_W-1:0] TE_L = CMP_W'(TABLE_ENTRIES);

	logic [16:0] cb_q;
	logic [27:0] ds_q;
	logic [16:0] eiu_q;
	logic [27:0] end_q;

	op_t op_q;
	logic [27:0] cl_q, val_q, cur_q;
	logic [31:0] off_q, prod_q, add_q;
	logic [CNT_W-1:0] steps_q, idx_q;
	logic [27:0] res_p_q;
	logic [31:0] addr_p_q;
	st_t st_p_q;

	logic [IDX_W-1:0] ram_addr;
	logic [27:0] ram_wdata, rdata;
	logic [CMP_W-1:0] eiu_w, lim;
	logic [27:0] mul_c;
	logic [31:0] rel, cb_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q <= CLUSTER_BYTES_RST;
			ds_q <= DATA_START_RST;
			eiu_q <= ENTRIES_IN_USE_RST;
			end_q <= END_MARKER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CLUSTER_BYTES: cb_q <= cfg_data[16:0];
				CFG_DATA_START: ds_q <= cfg_data;
				CFG_ENTRIES_IN_USE: eiu_q <= cfg_data[16:0];
				CFG_END_MARKER: end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fcce_ram #(.WIDTH(28), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk(clk), .en(cmd.ram_en), .we(cmd.ram_we), .addr(ram_addr),
		.wdata(ram_wdata), .rdata(rdata)
	);

	always_comb begin
		case (cmd.asel)
			A_CUR: ram_addr = cur_q[IDX_W-1:0];
			A_CL: ram_addr = cl_q[IDX_W-1:0];
			A_IDX: ram_addr = idx_q[IDX_W-1:0];
			default: ram_addr = rdata[IDX_W-1:0];
		endcase
		case (cmd.wsel)
			W_VAL: ram_wdata = val_q;
			W_END: ram_wdata = end_q;
			W_ZERO: ram_wdata = 28'd0;
			default: ram_wdata = 28'(idx_q);
		endcase
	end

	// Byte address of a cluster: (c - 2 + data start) * cluster bytes, wrapping.
	assign mul_c = cmd.mul_idx ? 28'(idx_q) : cur_q;
	assign rel = {4'd0, mul_c} - 32'd2 + {4'd0, ds_q};
	assign cb_w = {15'd0, cb_q};
	assign eiu_w = CMP_W'(eiu_q);
	assign lim = (eiu_w < TE_L) ? eiu_w : TE_L;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(op);
			cl_q <= cluster;
			val_q <= value;
			off_q <= offset;
			cur_q <= cluster;
			steps_q <= '0;
			res_p_q <= 28'd0;
			addr_p_q <= 32'd0;
			st_p_q <= ST_OK;
		end else begin
			if (cmd.cur_ld) cur_q <= rdata;
			if (cmd.step_inc) steps_q <= steps_q + CNT_W'(1);
			if (cmd.off_sub) off_q <= off_q - cb_w;
			if (cmd.res_ld) begin
				case (cmd.rsel)
					R_RD: res_p_q <= rdata;
					R_IDX: res_p_q <= 28'(idx_q);
					default: res_p_q <= cur_q;
				endcase
			end
			if (cmd.st_ld) st_p_q <= cmd.st_val;
			if (cmd.addr_ld) addr_p_q <= prod_q + add_q;
		end
		if (cmd.idx_init) begin
			idx_q <= CNT_W'(2);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (cmd.mul_go) begin
			prod_q <= 32'(rel * cb_w);
			case (cmd.addsel)
				ADD_OFF: add_q <= off_q;
				ADD_CB: add_q <= cb_w;
				default: add_q <= 32'd0;
			endcase
		end
		if (cmd.out_ld) begin
			result_cluster <= res_p_q;
			address <= addr_p_q;
			status <= st_p_q;
		end
	end

	always_comb begin
		sts.op = op_q;
		sts.cur_range = CMP_W'(cur_q) >= TE_L;
		sts.cur_end = cur_q >= end_q;
		sts.cur_start = cur_q == cl_q;
		sts.rd_end = rdata >= end_q;
		sts.rd_range = CMP_W'(rdata) >= TE_L;
		sts.rd_zero = rdata == 28'd0;
		sts.step_max = CMP_W'(steps_q) >= TE_L;
		sts.idx_end = CMP_W'(idx_q) >= lim;
		sts.off_ge = off_q >= cb_w;
	end

endmodule

### rtl/fcce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain engine controller
// Sequences table accesses for each command and owns the handshakes.
// ----------------------------------------------------------------------------
module fcce_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input fcce_pkg::sts_t sts,
	output fcce_pkg::cmd_t cmd
);
	import fcce_pkg::*;

	state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_DONE;
				case (sts.op) inside
					OP_READ, OP_APPEND, OP_SEEK: begin
						if (sts.cur_range) begin
							cmd.st_ld = 1'b1;
							cmd.st_val = ST_RANGE;
						end else begin
							cmd.ram_en = 1'b1;
							cmd.asel = A_CUR;
							if (sts.op == OP_READ) state_d = S_RD_WAIT;
							else if (sts.op == OP_APPEND) state_d = S_APP_WALK;
							else state_d = S_SEEK_TEST;
						end
					end
					OP_WRITE: begin
						if (sts.cur_range) begin
							cmd.st_ld = 1'b1;
							cmd.st_val = ST_RANGE;
						end else begin
							cmd.ram_en = 1'b1;
							cmd.ram_we = 1'b1;
							cmd.asel = A_CUR;
							cmd.wsel = W_VAL;
						end
					end
					OP_FIND: begin
						cmd.idx_init = 1'b1;
						state_d = S_SCAN_RD;
					end
					OP_TRUNC, OP_FREE: state_d = S_CUT_TEST;
					default: ;
				endcase
			end
			S_RD_WAIT: begin
				cmd.res_ld = 1'b1;
				cmd.rsel = R_RD;
				state_d = S_DONE;
			end
			S_SCAN_RD: begin
				if (sts.idx_end) begin
					cmd.st_ld = 1'b1;
					cmd.st_val = ST_NOFREE;
					state_d = S_DONE;
				end else begin
					cmd.ram_en = 1'b1;
					cmd.asel = A_IDX;
					state_d = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (!sts.rd_zero) begin
					cmd.idx_inc = 1'b1;
					state_d = S_SCAN_RD;
				end else if (sts.op == OP_FIND) begin
					cmd.res_ld = 1'b1;
					cmd.rsel = R_IDX;
					state_d = S_DONE;
				end else begin
					state_d = S_APP_LINK;
				end
			end
			S_APP_WALK: begin
				if (sts.rd_end) begin
					cmd.idx_init = 1'b1;
					state_d = S_SCAN_RD;
				end else if (sts.rd_range || sts.step_max) begin
					cmd.st_ld = 1'b1;
					cmd.st_val = sts.rd_range ? ST_RANGE : ST_LIMIT;
					state_d = S_DONE;
				end else begin
					cmd.step_inc = 1'b1;
					cmd.cur_ld = 1'b1;
					cmd.ram_en = 1'b1;
					cmd.asel = A_RD;
				end
			end
			S_APP_LINK: begin
				cmd.ram_en = 1'b1;
				cmd.ram_we = 1'b1;
				cmd.asel = A_CUR;
				cmd.wsel = W_IDX;
				state_d = S_APP_MARK;
			end
			S_APP_MARK: begin
				cmd.ram_en = 1'b1;
				cmd.ram_we = 1'b1;
				cmd.asel = A_IDX;
				cmd.wsel = W_END;
				cmd.res_ld = 1'b1;
				cmd.rsel = R_IDX;
				cmd.mul_go = 1'b1;
				cmd.mul_idx = 1'b1;
				cmd.addsel = ADD_ZERO;
				state_d = S_ADD;
			end
			S_CUT_TEST: begin
				if (sts.cur_end) begin
					state_d = (sts.op == OP_FREE) ? S_FREE_FIN : S_DONE;
				end else if (sts.cur_range || sts.step_max) begin
					cmd.st_ld = 1'b1;
					cmd.st_val = sts.cur_range ? ST_RANGE : ST_LIMIT;
					state_d = S_DONE;
				end else begin
					cmd.step_inc = 1'b1;
					cmd.ram_en = 1'b1;
					cmd.asel = A_CUR;
					state_d = S_CUT_WR;
				end
			end
			S_CUT_WR: begin
				cmd.ram_en = 1'b1;
				cmd.ram_we = 1'b1;
				cmd.asel = A_CUR;
				cmd.wsel = sts.cur_start ? W_END : W_ZERO;
				cmd.cur_ld = 1'b1;
				state_d = S_CUT_TEST;
			end
			S_FREE_FIN: begin
				cmd.asel = A_CL;
				cmd.wsel = W_ZERO;
				if (sts.cur_range && sts.cur_start) begin
					cmd.st_ld = 1'b1;
					cmd.st_val = ST_RANGE;
				end else begin
					cmd.ram_en = 1'b1;
					cmd.ram_we = 1'b1;
				end
				state_d = S_DONE;
			end
			S_SEEK_TEST: begin
				cmd.res_ld = 1'b1;
				cmd.rsel = R_CUR;
				cmd.mul_go = 1'b1;
				state_d = S_ADD;
				if (!sts.off_ge) begin
					cmd.addsel = ADD_OFF;
				end else if (sts.rd_end) begin
					cmd.st_ld = 1'b1;
					cmd.st_val = ST_ENDED;
					cmd.addsel = ADD_CB;
				end else if (sts.rd_range || sts.step_max) begin
					cmd.st_ld = 1'b1;
					cmd.st_val = sts.rd_range ? ST_RANGE : ST_LIMIT;
					cmd.addsel = ADD_ZERO;
				end else begin
					cmd.res_ld = 1'b0;
					cmd.mul_go = 1'b0;
					cmd.step_inc = 1'b1;
					cmd.cur_ld = 1'b1;
					cmd.off_sub = 1'b1;
					cmd.ram_en = 1'b1;
					cmd.asel = A_RD;
					state_d = S_SEEK_TEST;
				end
			end
			S_ADD: begin
				cmd.addr_ld = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### rtl/fat_cluster_chain_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT32 cluster chain engine
// Holds an allocation table and serves read, write, free search, append,
// truncate, free chain and seek commands, one result beat per command beat.
// ----------------------------------------------------------------------------
// Usage: a command beat (op, cluster, value, offset) is taken when in_valid is
// high and in_stall is low. The engine works on one command at a time and
// holds in_stall high from the beat after acceptance until its result has
// been moved into the output register. Each command yields exactly one
// result beat (result_cluster, address, status), offered with out_valid.
// Accepted commands step through controller states: a read waits for its RAM
// data, a free search reads and checks each table entry in turn, append and
// seek walk the chain one link per step, truncate and free read and then
// rewrite each link, and append or seek form the byte address with a multiply
// followed by a registered sum. The next command can be taken in the cycle
// after the result is loaded. The single table RAM port, one access per cycle,
// paces these steps. When the receiver stalls, the finished result stays in
// the output register and a new command may already be accepted; the next
// result waits until the register is taken. Reset clears the controller and
// sets the configuration registers to their defaults; table contents are
// undefined until written, so load the table with write commands first.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user
// must write it only while the engine is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine #(
	parameter int unsigned TABLE_ENTRIES = fcce_pkg::TABLE_ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] op,
	input logic [27:0] cluster,
	input logic [27:0] value,
	input logic [31:0] offset,
	output logic out_valid,
	input logic out_stall,
	output logic [27:0] result_cluster,
	output logic [31:0] address,
	output logic [2:0] status,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [27:0] cfg_data
);
	import fcce_pkg::*;

	// Commands from the controller and status flags back from the datapath.
	cmd_t cmd;
	sts_t sts;

	fcce_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	fcce_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.op(op), .cluster(cluster), .value(value), .offset(offset),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_cluster(result_cluster), .address(address), .status(status)
	);

endmodule

### rtl/fcce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cluster chain engine port checker
// Watches the engine's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module fcce_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [27:0] result_cluster,
	input logic [31:0] address,
	input logic [2:0] status
);
	import fcce_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_cluster)
			&& $stable(address) && $stable(status))
		else $error("stalled result beat changed or dropped");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("engine took no busy cycle after a command beat");

	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NOFREE |-> result_cluster == 28'd0
			&& address == 32'd0)
		else $error("no-free result carries a cluster or address");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_RANGE)
		else $error("status code out of range");

endmodule

bind fat_cluster_chain_engine fcce_checker u_fcce_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.result_cluster(result_cluster), .address(address), .status(status)
);

### dv/fat_cluster_chain_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FAT cluster chain engine testbench
// Loads a small window of the allocation table, runs a directed table of
// commands and then random command streams under several register settings.
// Each result beat is held to a cycle-free table model here or a typed-in one.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine_tb;
	import fcce_pkg::*;

	// The table is only loaded over a small window. Entries above it stay
	// unwritten unless a random write lands there.
	localparam int unsigned TBL_DEPTH = 65536;
	localparam int unsigned WIN = 48;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int unsigned PHASE_ITEMS = 300;
	localparam int unsigned LONG_WALK = 400;
	localparam int unsigned MAX_LONG = 3;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned IDLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] op;
	logic [27:0] cluster;
	logic [27:0] value;
	logic [31:0] offset;
	logic out_valid;
	logic out_stall;
	logic [27:0] result_cluster;
	logic [31:0] address;
	logic [2:0] status;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [27:0] cfg_data;

	fat_cluster_chain_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.cluster(cluster),
		.value(value),
		.offset(offset),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_cluster(result_cluster),
		.address(address),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Table model. The mirror of the table, which entries were ever written,
	// and an undo log so that a candidate command can be tried and retracted.
	// ------------------------------------------------------------------------
	bit [27:0] fat_mem [TBL_DEPTH];
	bit loaded [TBL_DEPTH];
	int unsigned undo_idx [$];
	bit [27:0] undo_val [$];
	bit undo_ld [$];
	bit touched_unloaded;
	int unsigned walk_steps;

	logic [16:0] m_cb;
	logic [27:0] m_ds;
	logic [16:0] m_eiu;
	logic [27:0] m_em;

	typedef struct {
		logic [27:0] res;
		logic [31:0] addr;
		logic [2:0] st;
	} fat_result_t;

	fat_result_t pending_results [$];
	int unsigned errors;
	int unsigned long_walks;

	function automatic bit [27:0] tbl_rd(int unsigned i);
		if (!loaded[i])
			touched_unloaded = 1'b1;
		return fat_mem[i];
	endfunction

	function automatic void tbl_wr(int unsigned i, bit [27:0] v);
		undo_idx.push_back(i);
		undo_val.push_back(fat_mem[i]);
		undo_ld.push_back(loaded[i]);
		fat_mem[i] = v;
		loaded[i] = 1'b1;
	endfunction

	function automatic void retract();
		while (undo_idx.size() != 0) begin
			fat_mem[undo_idx[$]] = undo_val[$];
			loaded[undo_idx[$]] = undo_ld[$];
			void'(undo_idx.pop_back());
			void'(undo_val.pop_back());
			void'(undo_ld.pop_back());
		end
	endfunction

	function automatic logic [31:0] byte_at(logic [31:0] c, logic [31:0] o);
		logic [31:0] rel;
		rel = c - 32'd2 + {4'd0, m_ds};
		return rel * {15'd0, m_cb} + o;
	endfunction

	function automatic logic [31:0] first_free_cluster();
		logic [31:0] lim;
		lim = ({15'd0, m_eiu} > TBL_DEPTH) ? TBL_DEPTH : {15'd0, m_eiu};
		for (logic [31:0] i = 2; i < lim; i++) begin
			walk_steps++;
			if (tbl_rd(i) == 28'd0)
				return i;
		end
		return 32'd0;
	endfunction

	// Head of the chain gets the end marker, every later link is freed.
	function automatic st_t cut_chain(logic [31:0] start);
		logic [31:0] cur;
		logic [31:0] nxt;
		logic [31:0] steps;
		cur = start;
		steps = 0;
		while (cur < {4'd0, m_em}) begin
			if (cur >= TBL_DEPTH)
				return ST_RANGE;
			if (steps >= TBL_DEPTH)
				return ST_LIMIT;
			steps++;
			walk_steps++;
			nxt = tbl_rd(cur);
			tbl_wr(cur, (cur == start) ? m_em : 28'd0);
			cur = nxt;
		end
		return ST_OK;
	endfunction

	function automatic fat_result_t run_command(logic [2:0] c_op, logic [27:0] c_cl,
			logic [27:0] c_val, logic [31:0] c_off);
		fat_result_t r;
		logic [31:0] cl;
		logic [31:0] cur;
		logic [31:0] nxt;
		logic [31:0] steps;
		logic [31:0] fr;
		logic [31:0] off;
		st_t st;
		cl = {4'd0, c_cl};
		off = c_off;
		r.res = '0;
		r.addr = '0;
		st = ST_OK;
		steps = 0;
		case (c_op)
			OP_READ: begin
				if (cl >= TBL_DEPTH)
					st = ST_RANGE;
				else
					r.res = tbl_rd(cl);
			end
			OP_WRITE: begin
				if (cl >= TBL_DEPTH)
					st = ST_RANGE;
				else
					tbl_wr(cl, c_val);
			end
			OP_FIND: begin
				fr = first_free_cluster();
				r.res = fr[27:0];
				if (fr == 0)
					st = ST_NOFREE;
			end
			OP_APPEND: begin
				if (cl >= TBL_DEPTH) begin
					st = ST_RANGE;
				end else begin
					cur = cl;
					nxt = tbl_rd(cur);
					while (nxt < {4'd0, m_em} && st == ST_OK) begin
						if (nxt >= TBL_DEPTH)
							st = ST_RANGE;
						else if (steps >= TBL_DEPTH)
							st = ST_LIMIT;
						else begin
							steps++;
							walk_steps++;
							cur = nxt;
							nxt = tbl_rd(cur);
						end
					end
					if (st == ST_OK) begin
						fr = first_free_cluster();
						if (fr == 0) begin
							st = ST_NOFREE;
						end else begin
							tbl_wr(cur, fr[27:0]);
							tbl_wr(fr, m_em);
							r.res = fr[27:0];
							r.addr = byte_at(fr, 32'd0);
						end
					end
				end
			end
			OP_TRUNC: st = cut_chain(cl);
			OP_FREE: begin
				st = cut_chain(cl);
				if (st == ST_OK) begin
					if (cl >= TBL_DEPTH)
						st = ST_RANGE;
					else
						tbl_wr(cl, 28'd0);
				end
			end
			OP_SEEK: begin
				if (cl >= TBL_DEPTH) begin
					st = ST_RANGE;
				end else begin
					cur = cl;
					nxt = tbl_rd(cur);
					while (off >= {15'd0, m_cb} && st == ST_OK) begin
						if (nxt >= {4'd0, m_em})
							st = ST_ENDED;
						else if (nxt >= TBL_DEPTH)
							st = ST_RANGE;
						else if (steps >= TBL_DEPTH)
							st = ST_LIMIT;
						else begin
							steps++;
							walk_steps++;
							cur = nxt;
							nxt = tbl_rd(cur);
							off = off - {15'd0, m_cb};
						end
					end
					r.res = cur[27:0];
					if (st == ST_OK)
						r.addr = byte_at(cur, off);
					else if (st == ST_ENDED)
						r.addr = byte_at(cur, {15'd0, m_cb});
					else
						r.addr = byte_at(cur, 32'd0);
				end
			end
			default: ;
		endcase
		r.st = st;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Command side. A gap of 0 keeps in_valid high across back-to-back beats.
	// Idle draws switch off for whole stretches so dense traffic is seen too.
	// ------------------------------------------------------------------------
	int unsigned beats_sent;

	task automatic send_beat(logic [2:0] c_op, logic [27:0] c_cl, logic [27:0] c_val,
			logic [31:0] c_off);
		int unsigned gap;
		gap = ((beats_sent / 64) % 3 == 0) ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c_op;
		cluster <= c_cl;
		value <= c_val;
		offset <= c_off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	// Predicts a command, queues the result (or a typed-in one) and sends it.
	task automatic issue(logic [2:0] c_op, logic [27:0] c_cl, logic [27:0] c_val,
			logic [31:0] c_off, bit typed, fat_result_t want);
		fat_result_t r;
		undo_idx.delete();
		undo_val.delete();
		undo_ld.delete();
		r = run_command(c_op, c_cl, c_val, c_off);
		pending_results.push_back(typed ? want : r);
		send_beat(c_op, c_cl, c_val, c_off);
	endtask

	// Register writes go in only once the engine has drained.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || out_valid)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [27:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CLUSTER_BYTES: m_cb = data[16:0];
			CFG_DATA_START: m_ds = data;
			CFG_ENTRIES_IN_USE: m_eiu = data[16:0];
			default: m_em = data;
		endcase
	endtask

	task automatic set_regs(logic [16:0] cb, logic [27:0] ds, logic [16:0] eiu,
			logic [27:0] em);
		wait_drained();
		write_reg(CFG_CLUSTER_BYTES, {11'd0, cb});
		write_reg(CFG_DATA_START, ds);
		write_reg(CFG_ENTRIES_IN_USE, {11'd0, eiu});
		write_reg(CFG_END_MARKER, em);
	endtask

	// ------------------------------------------------------------------------
	// Random commands. A candidate that would read an entry that was never
	// written is retracted and redrawn; commands that walk or search past
	// LONG_WALK steps are rationed, MAX_LONG of them in the whole run.
	// ------------------------------------------------------------------------
	task automatic random_command();
		logic [2:0] c_op;
		logic [27:0] c_cl;
		logic [27:0] c_val;
		logic [31:0] c_off;
		int unsigned pick;
		fat_result_t r;
		fat_result_t none;
		bit ok;
		none = '{default: '0};
		ok = 1'b0;
		for (int attempt = 0; attempt < 50 && !ok; attempt++) begin
			pick = $urandom_range(0, 99);
			if (pick < 32) c_op = OP_WRITE;
			else if (pick < 45) c_op = OP_READ;
			else if (pick < 53) c_op = OP_FIND;
			else if (pick < 68) c_op = OP_APPEND;
			else if (pick < 76) c_op = OP_TRUNC;
			else if (pick < 83) c_op = OP_FREE;
			else if (pick < 98) c_op = OP_SEEK;
			else c_op = OP_UNUSED;
			case ($urandom_range(0, 24))
				0: c_cl = 28'($urandom);
				1: c_cl = 28'hFFFFFFF;
				2: c_cl = 28'(TBL_DEPTH - 1);
				3: c_cl = 28'(TBL_DEPTH);
				default: c_cl = 28'($urandom_range(0, WIN - 1));
			endcase
			case ($urandom_range(0, 9))
				0, 1: c_val = '0;
				2, 3, 4, 5: c_val = 28'($urandom_range(0, WIN - 1));
				6, 7: c_val = m_em;
				8: c_val = 28'($urandom);
				default: c_val = 28'hFFFFFFF;
			endcase
			if ($urandom_range(0, 3) == 0)
				c_off = $urandom;
			else
				c_off = $urandom_range(0, 4 * m_cb + 3);
			touched_unloaded = 1'b0;
			walk_steps = 0;
			undo_idx.delete();
			undo_val.delete();
			undo_ld.delete();
			r = run_command(c_op, c_cl, c_val, c_off);
			if (touched_unloaded || (walk_steps > LONG_WALK && long_walks >= MAX_LONG)) begin
				retract();
			end else begin
				if (walk_steps > LONG_WALK)
					long_walks++;
				ok = 1'b1;
			end
		end
		if (ok) begin
			pending_results.push_back(r);
			send_beat(c_op, c_cl, c_val, c_off);
		end else begin
			// A write never reads the table, so it is always a safe fallback.
			issue(OP_WRITE, 28'($urandom_range(0, WIN - 1)), '0, $urandom, 1'b0, none);
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side. Stall draws come per beat; one long hold lets the engine
	// fill its output register and back up into its command input.
	// ------------------------------------------------------------------------
	bit hold_req;
	bit hold_done;
	int unsigned hold_count;
	int unsigned stall_left;
	int unsigned beats_taken;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
			hold_count = 0;
			hold_done = 1'b0;
			beats_taken = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: cluster %h addr %h st %0d",
						$time, result_cluster, address, status);
					errors++;
				end else begin
					if (result_cluster !== pending_results[0].res) begin
						$display("%0t: result_cluster expected %h actual %h", $time,
							pending_results[0].res, result_cluster);
						errors++;
					end
					if (address !== pending_results[0].addr) begin
						$display("%0t: address expected %h actual %h", $time,
							pending_results[0].addr, address);
						errors++;
					end
					if (status !== pending_results[0].st) begin
						$display("%0t: status expected %0d actual %0d", $time,
							pending_results[0].st, status);
						errors++;
					end
					void'(pending_results.pop_front());
				end
				beats_taken++;
				stall_left = ((beats_taken / 80) % 3 == 1) ? 0 : $urandom_range(0, 18);
			end
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				hold_count++;
				if (hold_count >= HOLD_CYCLES)
					hold_done = 1'b1;
			end else if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: the longest legal quiet stretch is an append that walks a chain
	// across the whole table and then searches all of it for a free entry.
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("fat_cluster_chain_engine_tb: done, errors");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// ------------------------------------------------------------------------
	// Directed table. Typed-in results are the ones that can be read straight
	// off the command: reset window contents, range errors, the unused code,
	// and a small hand-built chain at the reset cluster size.
	// ------------------------------------------------------------------------
	typedef struct {
		logic [2:0] c_op;
		logic [27:0] c_cl;
		logic [27:0] c_val;
		logic [31:0] c_off;
		bit typed;
		fat_result_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic dir_row_t mk(logic [2:0] o, logic [27:0] c, logic [27:0] v,
			logic [31:0] f, bit t, logic [27:0] rr, logic [31:0] ra, logic [2:0] rs);
		dir_row_t d;
		d.c_op = o;
		d.c_cl = c;
		d.c_val = v;
		d.c_off = f;
		d.typed = t;
		d.want.res = rr;
		d.want.addr = ra;
		d.want.st = rs;
		return d;
	endfunction

	initial begin
		fat_result_t none;
		none = '{default: '0};
		errors = 0;
		long_walks = 0;
		beats_sent = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_READ;
		cluster = '0;
		value = '0;
		offset = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_CLUSTER_BYTES;
		cfg_data = '0;
		m_cb = CLUSTER_BYTES_RST;
		m_ds = DATA_START_RST;
		m_eiu = ENTRIES_IN_USE_RST;
		m_em = END_MARKER_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Keep the free search inside the loaded window, then load it.
		write_reg(CFG_ENTRIES_IN_USE, 28'(WIN));
		for (int unsigned i = 0; i < WIN; i++)
			issue(OP_WRITE, 28'(i), '0, '0, 1'b1, none);

		dir_rows.push_back(mk(OP_READ, 5, 0, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_READ, 28'hFFFFFFF, 0, 0, 1, 0, 0, ST_RANGE));
		dir_rows.push_back(mk(OP_WRITE, 28'hFFFFFFF, 1, 0, 1, 0, 0, ST_RANGE));
		dir_rows.push_back(mk(OP_WRITE, 2, 3, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_WRITE, 3, END_MARKER_RST, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_READ, 2, 0, 0, 1, 3, 0, ST_OK));
		dir_rows.push_back(mk(OP_FIND, 0, 0, 0, 1, 4, 0, ST_OK));
		dir_rows.push_back(mk(OP_APPEND, 2, 0, 0, 1, 4, 8192, ST_OK));
		dir_rows.push_back(mk(OP_SEEK, 2, 0, 5000, 1, 3, 5000, ST_OK));
		// Seeking past the end lands one cluster beyond the last one.
		dir_rows.push_back(mk(OP_SEEK, 2, 0, 32'hFFFFFFFF, 1, 4, 12288, ST_ENDED));
		dir_rows.push_back(mk(OP_SEEK, 28'h0100000, 0, 0, 1, 0, 0, ST_RANGE));
		dir_rows.push_back(mk(OP_TRUNC, 2, 0, 0, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_FREE, 2, 0, 0, 0, 0, 0, ST_OK));
		// A chain that starts at the end marker; the start itself is out of range.
		dir_rows.push_back(mk(OP_FREE, 28'hFFFFFFF, 0, 0, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_TRUNC, 28'hFFFFFFF, 0, 0, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_UNUSED, 28'hFFFFFFF, 28'hFFFFFFF, 32'hFFFFFFFF,
			1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_WRITE, 10, 28'hFFFFFFF, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_READ, 10, 0, 0, 1, 28'hFFFFFFF, 0, ST_OK));
		// Two entries pointing at each other: append walks to the step limit.
		dir_rows.push_back(mk(OP_WRITE, 11, 12, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_WRITE, 12, 11, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_APPEND, 11, 0, 0, 1, 0, 0, ST_LIMIT));
		dir_rows.push_back(mk(OP_TRUNC, 11, 0, 0, 0, 0, 0, ST_OK));
		// A link that points beyond the table stops seek and append.
		dir_rows.push_back(mk(OP_WRITE, 20, 28'h0050000, 0, 1, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_SEEK, 20, 0, 8192, 0, 0, 0, ST_OK));
		dir_rows.push_back(mk(OP_APPEND, 20, 0, 0, 1, 0, 0, ST_RANGE));

		foreach (dir_rows[i])
			issue(dir_rows[i].c_op, dir_rows[i].c_cl, dir_rows[i].c_val, dir_rows[i].c_off,
				dir_rows[i].typed, dir_rows[i].want);

		// Random phases, each under its own register setting, extremes first.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_regs(17'd512, 28'd0, 17'(WIN), END_MARKER_RST);
				1: set_regs(17'd65536, 28'hFFFFFFF, 17'd3, 28'hFFFFFFF);
				2: set_regs(17'd0, 28'($urandom), 17'd65536, 28'd2);
				3: set_regs(17'($urandom_range(512, 65536)), 28'($urandom),
					17'($urandom_range(3, WIN)), 28'($urandom_range(WIN / 2, WIN)));
				4: set_regs(17'($urandom), 28'($urandom), 17'(WIN), END_MARKER_RST);
				default: set_regs(CLUSTER_BYTES_RST, DATA_START_RST, 17'(WIN),
					END_MARKER_RST);
			endcase
			if (ph == 0)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS)
				random_command();
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("fat_cluster_chain_engine_tb: done, clean");
		else
			$display("fat_cluster_chain_engine_tb: done, errors");
		$finish;
	end

endmodule

### files.f
rtl/fcce_pkg.sv
rtl/fcce_ram.sv
rtl/fcce_dp.sv
rtl/fcce_ctrl.sv
rtl/fat_cluster_chain_engine.sv
rtl/fcce_checker.sv
dv/fat_cluster_chain_engine_tb.sv
